/* design/fsg_pkg.sv */
// Package for the falling sand grid block: tile and beat types, codes,
// and the shade generator helpers. Used by the interface and the step module.
// No dependencies.
package fsg_pkg;

	localparam int GRID_DIM_DEF = 64;
	localparam int SHADE_COUNT = 5;
	localparam logic [15:0] LFSR_TAPS = 16'hB400;

	localparam logic [1:0] KIND_AIR = 2'd0;
	localparam logic [1:0] KIND_SAND = 2'd1;
	localparam logic [1:0] KIND_WATER = 2'd2;

	localparam logic [1:0] FUNC_PLACE = 2'd0;
	localparam logic [1:0] FUNC_READ = 2'd1;
	localparam logic [1:0] FUNC_SWEEP = 2'd2;

	typedef struct packed {
		logic [1:0] kind;
		logic [2:0] shade;
	} tile_t;

	typedef struct packed {
		logic [1:0] func;
		logic [5:0] col_x;
		logic [5:0] row_y;
		logic [1:0] tile_kind;
	} req_t;

	typedef struct packed {
		logic [1:0] cell_kind;
		logic [2:0] cell_shade;
	} rsp_t;

	typedef struct packed {
		logic [15:0] random_seed;
	} cfg_t;

	function automatic logic [15:0] lfsr_step(input logic [15:0] v);
		logic [15:0] n;
		n = v >> 1;
		if (v[0]) begin
			n = n ^ LFSR_TAPS;
		end
		return n;
	endfunction

	// Sixteen is one more than a multiple of five, so nibble sums keep the residue.
	function automatic logic [2:0] shade_of(input logic [15:0] v);
		logic [5:0] s;
		logic [4:0] t;
		s = 6'(v[3:0]) + 6'(v[7:4]) + 6'(v[11:8]) + 6'(v[15:12]);
		t = 5'(s[5:4]) + 5'(s[3:0]);
		for (int i = 0; i < 3; i++) begin
			if (t >= 5'(SHADE_COUNT)) begin
				t = t - 5'(SHADE_COUNT);
			end
		end
		return t[2:0];
	endfunction

endpackage

/* design/fsg_chan_if.sv */
// Valid/ready channel carrying one payload beat of a chosen type.
// Depends on fsg_pkg for the default payload type.
interface fsg_chan_if #(parameter type payload_t = fsg_pkg::req_t);
	logic valid;
	logic ready;
	payload_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

/* design/fsg_ram.sv */
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module fsg_ram #(
	parameter int WIDTH = 5,
	parameter int DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		rd_data_q <= mem_q[rd_addr];
	end

	assign rd_data = rd_data_q;

endmodule

/* design/falling_sand_grid_step.sv */
// Falling sand grid: place, read and in-place sweep over a tile RAM; needs fsg_pkg,
// fsg_chan_if and fsg_ram. One item is worked at a time and no request is taken meanwhile.
// Place passes through ST_PLACE and read through ST_READ, then both through ST_RESULT (an
// ignored item goes straight to ST_RESULT), which holds while the output register is full;
// a sweep visits the tiles one at a time through the single read port. Reset clears the RAM
// to air, one entry per cycle, before requests are taken; config beats are taken.
module falling_sand_grid_step #(
	parameter int GRID_DIM = fsg_pkg::GRID_DIM_DEF
) (
	input logic clk,
	input logic arst_n,
	fsg_chan_if.sink req,
	fsg_chan_if.source rsp,
	fsg_chan_if.sink cfg
);

	localparam int CW = $clog2(GRID_DIM);
	localparam int AW = 2 * CW;
	localparam int DEPTH = 1 << AW;
	localparam logic [CW-1:0] LAST = CW'(GRID_DIM - 1);

	typedef enum logic [3:0] {
		ST_CLEAR, ST_IDLE, ST_PLACE, ST_READ, ST_SW_ISSUE, ST_SW_HERE,
		ST_SW_BELOW, ST_SW_LEFT, ST_SW_RIGHT, ST_SW_WR_FROM, ST_SW_WR_TO, ST_RESULT
	} state_t;

	state_t state_q;
	logic [AW-1:0] clr_q;
	logic [CW-1:0] x_q, y_q;
	logic [1:0] kind_q;
	logic [2:0] here_shade_q;
	logic [AW-1:0] to_q;
	logic [15:0] lfsr_q;
	logic [1:0] res_kind_q;
	logic [2:0] res_shade_q;
	logic out_valid_q;
	fsg_pkg::rsp_t out_data_q;

	logic [AW-1:0] rd_addr, wr_addr;
	logic wr_en;
	fsg_pkg::tile_t wr_data, rd_tile;
	logic cell_done, draw;
	logic [15:0] lfsr_nxt;
	logic [2:0] shade_nxt;
	logic [CW-1:0] req_x, req_y;
	logic req_inside;
	logic [AW-1:0] here_addr, below_addr, left_addr, right_addr;
	logic x_last, y_last;

	fsg_ram #(.WIDTH($bits(fsg_pkg::tile_t)), .DEPTH(DEPTH)) u_ram (
		.clk(clk),
		.wr_en(wr_en),
		.wr_addr(wr_addr),
		.wr_data(wr_data),
		.rd_addr(rd_addr),
		.rd_data(rd_tile)
	);

	assign req_x = CW'(req.data.col_x);
	assign req_y = CW'(req.data.row_y);
	assign req_inside = ({3'b0, req.data.col_x} < 9'(GRID_DIM)) &&
		({3'b0, req.data.row_y} < 9'(GRID_DIM));
	assign here_addr = {x_q, y_q};
	assign below_addr = {x_q, y_q + CW'(1)};
	assign left_addr = {x_q - CW'(1), y_q + CW'(1)};
	assign right_addr = {x_q + CW'(1), y_q + CW'(1)};
	assign x_last = (x_q == LAST);
	assign y_last = (y_q == LAST);
	assign lfsr_nxt = fsg_pkg::lfsr_step(lfsr_q);
	assign shade_nxt = fsg_pkg::shade_of(lfsr_nxt);
	assign draw = (state_q == ST_SW_WR_TO) ||
		(state_q == ST_PLACE && kind_q == fsg_pkg::KIND_SAND);

	assign req.ready = (state_q == ST_IDLE);
	assign cfg.ready = 1'b1;
	assign rsp.valid = out_valid_q;
	assign rsp.data = out_data_q;

	always_comb begin
		rd_addr = here_addr;
		wr_en = 1'b0;
		wr_addr = here_addr;
		wr_data = '0;
		cell_done = 1'b0;
		unique case (state_q)
			ST_CLEAR: begin
				wr_en = 1'b1;
				wr_addr = clr_q;
			end
			ST_IDLE: begin
				rd_addr = {req_x, req_y};
			end
			ST_PLACE: begin
				wr_en = 1'b1;
				wr_data.kind = kind_q;
				wr_data.shade = (kind_q == fsg_pkg::KIND_SAND) ? shade_nxt : rd_tile.shade;
			end
			ST_SW_HERE: begin
				if (rd_tile.kind != fsg_pkg::KIND_SAND || y_last) begin
					cell_done = 1'b1;
				end else begin
					rd_addr = below_addr;
				end
			end
			ST_SW_BELOW: begin
				if (rd_tile.kind == fsg_pkg::KIND_SAND) begin
					if (x_q != '0) begin
						rd_addr = left_addr;
					end else if (!x_last) begin
						rd_addr = right_addr;
					end else begin
						cell_done = 1'b1;
					end
				end else if (rd_tile.kind != fsg_pkg::KIND_AIR) begin
					cell_done = 1'b1;
				end
			end
			ST_SW_LEFT: begin
				if (rd_tile.kind != fsg_pkg::KIND_AIR) begin
					if (!x_last) begin
						rd_addr = right_addr;
					end else begin
						cell_done = 1'b1;
					end
				end
			end
			ST_SW_RIGHT: begin
				if (rd_tile.kind != fsg_pkg::KIND_AIR) begin
					cell_done = 1'b1;
				end
			end
			ST_SW_WR_FROM: begin
				wr_en = 1'b1;
				wr_data.kind = fsg_pkg::KIND_AIR;
				wr_data.shade = here_shade_q;
			end
			ST_SW_WR_TO: begin
				wr_en = 1'b1;
				wr_addr = to_q;
				wr_data.kind = fsg_pkg::KIND_SAND;
				wr_data.shade = shade_nxt;
				cell_done = 1'b1;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			clr_q <= '0;
			x_q <= '0;
			y_q <= '0;
			kind_q <= '0;
			here_shade_q <= '0;
			to_q <= '0;
			lfsr_q <= 16'd1;
			res_kind_q <= '0;
			res_shade_q <= '0;
			out_valid_q <= 1'b0;
			out_data_q <= '0;
		end else begin
			if (cfg.valid) begin
				lfsr_q <= (cfg.data.random_seed == '0) ? 16'd1 : cfg.data.random_seed;
			end else if (draw) begin
				lfsr_q <= lfsr_nxt;
			end

			if (rsp.ready && state_q != ST_RESULT) begin
				out_valid_q <= 1'b0;
			end

			if (cell_done) begin
				if (x_last && y_q == '0) begin
					state_q <= ST_RESULT;
				end else begin
					state_q <= ST_SW_ISSUE;
					if (y_q == '0) begin
						x_q <= x_q + CW'(1);
						y_q <= LAST;
					end else begin
						y_q <= y_q - CW'(1);
					end
				end
			end else begin
				unique case (state_q)
					ST_CLEAR: begin
						clr_q <= clr_q + AW'(1);
						if (clr_q == '1) begin
							state_q <= ST_IDLE;
						end
					end
					ST_IDLE: begin
						if (req.valid) begin
							x_q <= req_x;
							y_q <= req_y;
							kind_q <= req.data.tile_kind;
							res_kind_q <= '0;
							res_shade_q <= '0;
							unique case (req.data.func)
								fsg_pkg::FUNC_PLACE: begin
									if (req_inside && req.data.tile_kind <= fsg_pkg::KIND_WATER) begin
										state_q <= ST_PLACE;
									end else begin
										state_q <= ST_RESULT;
									end
								end
								fsg_pkg::FUNC_READ: begin
									state_q <= req_inside ? ST_READ : ST_RESULT;
								end
								fsg_pkg::FUNC_SWEEP: begin
									x_q <= '0;
									y_q <= LAST;
									state_q <= ST_SW_ISSUE;
								end
								default: begin
									state_q <= ST_RESULT;
								end
							endcase
						end
					end
					ST_PLACE: begin
						state_q <= ST_RESULT;
					end
					ST_READ: begin
						res_kind_q <= rd_tile.kind;
						res_shade_q <= rd_tile.shade;
						state_q <= ST_RESULT;
					end
					ST_SW_ISSUE: begin
						state_q <= ST_SW_HERE;
					end
					ST_SW_HERE: begin
						here_shade_q <= rd_tile.shade;
						state_q <= ST_SW_BELOW;
					end
					ST_SW_BELOW: begin
						if (rd_tile.kind == fsg_pkg::KIND_AIR) begin
							to_q <= below_addr;
							state_q <= ST_SW_WR_FROM;
						end else begin
							state_q <= (x_q != '0) ? ST_SW_LEFT : ST_SW_RIGHT;
						end
					end
					ST_SW_LEFT: begin
						if (rd_tile.kind == fsg_pkg::KIND_AIR) begin
							to_q <= left_addr;
							state_q <= ST_SW_WR_FROM;
						end else begin
							state_q <= ST_SW_RIGHT;
						end
					end
					ST_SW_RIGHT: begin
						to_q <= right_addr;
						state_q <= ST_SW_WR_FROM;
					end
					ST_SW_WR_FROM: begin
						state_q <= ST_SW_WR_TO;
					end
					ST_RESULT: begin
						if (!out_valid_q || rsp.ready) begin
							out_valid_q <= 1'b1;
							out_data_q.cell_kind <= res_kind_q;
							out_data_q.cell_shade <= res_shade_q;
							state_q <= ST_IDLE;
						end
					end
					default: begin
						state_q <= ST_IDLE;
					end
				endcase
			end
		end
	end

	a_lfsr_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		lfsr_q != '0)
		else $error("Shade generator reached the all-zero state.");

	a_no_result_in_clear: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_CLEAR |-> !out_valid_q)
		else $error("Result beat presented during the clearing pass.");

	a_move_pairs: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_SW_WR_TO |-> $past(state_q) == ST_SW_WR_FROM)
		else $error("Grain written to its target without vacating its source.");

	a_result_waits: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_RESULT && out_valid_q && !rsp.ready |=> state_q == ST_RESULT)
		else $error("Result dropped while the output register was still full.");

endmodule
